// ===== sv/vno_pkg.sv =====
// Shared constants, types and small helper functions for the voxel occlusion stencil.
`default_nettype none

package vno_pkg;

    // Largest supported row length and plane height
    localparam int MAX_ROW  = 32;
    localparam int MAX_ROWS = 32;

    // Field widths
    localparam int DENS_W   = 8;
    localparam int POSXZ_W  = 5;
    localparam int POSY_W   = 8;
    localparam int DIMXZ_W  = 6;
    localparam int DIMY_W   = 8;
    localparam int SUM_W    = 11;

    // Plane store banking: 3 x 3 banks on (x mod 3, z mod 3), both plane slots per bank
    localparam int NUM_BANKS  = 9;
    localparam int BANK_IDX_W = 4;
    localparam int QADDR_W    = 7;
    localparam int BANK_AW    = QADDR_W + 1;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // floor(s / 6) == (s * RECIP6) >> RECIP6_SH for every s below 2048
    localparam int RECIP6    = 2731;
    localparam int RECIP6_SH = 14;
    localparam int PROD_W    = 23;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd2;

    localparam logic [DIMXZ_W-1:0] DIM_XZ_RESET = 6'd18;
    localparam logic [DIMY_W-1:0]  DIM_Y_RESET  = 8'd18;
    localparam logic [DIMXZ_W-1:0] DIM_XZ_MIN   = 6'd3;
    localparam logic [DIMXZ_W-1:0] DIM_X_MAX    = DIMXZ_W'(MAX_ROW);
    localparam logic [DIMXZ_W-1:0] DIM_Z_MAX    = DIMXZ_W'(MAX_ROWS);
    localparam logic [DIMY_W-1:0]  DIM_Y_MIN    = 8'd3;

    // Five neighbours plus centre, as read from the plane store
    typedef struct packed {
        logic [DENS_W-1:0] centre;
        logic [DENS_W-1:0] below;
        logic [DENS_W-1:0] x_lo;
        logic [DENS_W-1:0] x_hi;
        logic [DENS_W-1:0] z_lo;
        logic [DENS_W-1:0] z_hi;
    } nbr_t;

    // Residue mod 3 of a 5-bit coordinate (constant table)
    function automatic logic [1:0] mod3(input logic [POSXZ_W-1:0] v);
        logic [1:0] r;
        r = 2'd0;
        for (int i = 0; i < (1 << POSXZ_W); i++) begin
            if (POSXZ_W'(i) == v) r = 2'(i % 3);
        end
        return r;
    endfunction

    // Quotient by 3 of a 5-bit coordinate (constant table)
    function automatic logic [3:0] div3(input logic [POSXZ_W-1:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int i = 0; i < (1 << POSXZ_W); i++) begin
            if (POSXZ_W'(i) == v) q = 4'(i / 3);
        end
        return q;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] r);
        logic [1:0] o;
        case (r)
            2'd0:    o = 2'd1;
            2'd1:    o = 2'd2;
            default: o = 2'd0;
        endcase
        return o;
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] r);
        logic [1:0] o;
        case (r)
            2'd1:    o = 2'd0;
            2'd2:    o = 2'd1;
            default: o = 2'd2;
        endcase
        return o;
    endfunction

    // Address inside one bank for plane position (x, z): (z/3)*11 + x/3
    function automatic logic [QADDR_W-1:0] bank_addr(input logic [POSXZ_W-1:0] x,
                                                     input logic [POSXZ_W-1:0] z);
        logic [QADDR_W-1:0] zq;
        logic [QADDR_W-1:0] xq;
        zq = {3'd0, div3(z)};
        xq = {3'd0, div3(x)};
        return (zq << 3) + (zq << 1) + zq + xq;
    endfunction

    // Bank number for residues (rx, rz)
    function automatic logic [BANK_IDX_W-1:0] bank_idx(input logic [1:0] rx,
                                                       input logic [1:0] rz);
        return {1'b0, rz, 1'b0} + {2'd0, rz} + {2'd0, rx};
    endfunction

    function automatic logic [DIMXZ_W-1:0] sat_xz(input logic [DIMXZ_W-1:0] v,
                                                  input logic [DIMXZ_W-1:0] hi);
        logic [DIMXZ_W-1:0] o;
        o = v;
        if (v < DIM_XZ_MIN) o = DIM_XZ_MIN;
        if (v > hi) o = hi;
        return o;
    endfunction

    function automatic logic [DIMY_W-1:0] sat_y(input logic [DIMY_W-1:0] v);
        return (v < DIM_Y_MIN) ? DIM_Y_MIN : v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/vno_plane_store.sv =====
// Banked two-plane voxel store: one write and all six stencil reads per cycle.
`default_nettype none

module vno_plane_store (
    input  wire                              aclk,
    input  wire                              en,        // word accepted this cycle
    input  wire                              slot,      // plane slot of the incoming word
    input  wire [vno_pkg::POSXZ_W-1:0]       pos_x,
    input  wire [vno_pkg::POSXZ_W-1:0]       pos_z,
    input  wire [vno_pkg::DENS_W-1:0]        wr_data,
    output vno_pkg::nbr_t                    nbr        // valid the cycle after en
);

    logic [1:0] rx;
    logic [1:0] rz;
    logic [1:0] rx_reg;
    logic [1:0] rz_reg;
    logic [vno_pkg::POSXZ_W-1:0] x_lo;
    logic [vno_pkg::POSXZ_W-1:0] x_hi;
    logic [vno_pkg::POSXZ_W-1:0] z_lo;
    logic [vno_pkg::POSXZ_W-1:0] z_hi;
    logic [vno_pkg::POSXZ_W-1:0] xsel [3];
    logic [vno_pkg::POSXZ_W-1:0] zsel [3];
    logic [vno_pkg::DENS_W-1:0]  rd_a [vno_pkg::NUM_BANKS];
    logic [vno_pkg::DENS_W-1:0]  rd_b [vno_pkg::NUM_BANKS];
    logic [vno_pkg::BANK_AW-1:0] addr_b;

    assign rx     = vno_pkg::mod3(pos_x);
    assign rz     = vno_pkg::mod3(pos_z);
    assign x_lo   = pos_x - 5'd1;
    assign x_hi   = pos_x + 5'd1;
    assign z_lo   = pos_z - 5'd1;
    assign z_hi   = pos_z + 5'd1;
    assign addr_b = {slot, vno_pkg::bank_addr(pos_x, pos_z)};

    // Of three consecutive coordinates, pick the one landing in each residue class
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xsel[i] = pos_x;
            zsel[i] = pos_z;
            if (vno_pkg::mod3(x_lo) == 2'(i)) xsel[i] = x_lo;
            if (vno_pkg::mod3(x_hi) == 2'(i)) xsel[i] = x_hi;
            if (vno_pkg::mod3(z_lo) == 2'(i)) zsel[i] = z_lo;
            if (vno_pkg::mod3(z_hi) == 2'(i)) zsel[i] = z_hi;
        end
    end

    genvar k;
    generate
        for (k = 0; k < vno_pkg::NUM_BANKS; k++) begin : g_bank
            localparam logic [1:0] BX = 2'(k % 3);
            localparam logic [1:0] BZ = 2'(k / 3);

            logic [vno_pkg::DENS_W-1:0]  mem [vno_pkg::BANK_DEPTH];
            logic [vno_pkg::DENS_W-1:0]  rd_a_reg;
            logic [vno_pkg::DENS_W-1:0]  rd_b_reg;
            logic [vno_pkg::BANK_AW-1:0] addr_a;
            logic                        we;

            // Port A reads the previous plane: a row neighbour if this bank shares
            // the centre's z class, otherwise a column neighbour
            assign addr_a = (rz == BZ) ?
                            {~slot, vno_pkg::bank_addr(xsel[k % 3], pos_z)} :
                            {~slot, vno_pkg::bank_addr(pos_x, zsel[k / 3])};
            assign we     = en && (rx == BX) && (rz == BZ);

            // read-first: port B returns the plane two back before it is replaced
            always_ff @(posedge aclk) begin
                if (we) begin
                    mem[addr_b] <= wr_data;
                end
                if (en) begin
                    rd_a_reg <= mem[addr_a];
                    rd_b_reg <= mem[addr_b];
                end
            end

            assign rd_a[k] = rd_a_reg;
            assign rd_b[k] = rd_b_reg;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg <= rx;
            rz_reg <= rz;
        end
    end

    always_comb begin
        nbr.centre = rd_a[vno_pkg::bank_idx(rx_reg, rz_reg)];
        nbr.below  = rd_b[vno_pkg::bank_idx(rx_reg, rz_reg)];
        nbr.x_lo   = rd_a[vno_pkg::bank_idx(vno_pkg::dec3(rx_reg), rz_reg)];
        nbr.x_hi   = rd_a[vno_pkg::bank_idx(vno_pkg::inc3(rx_reg), rz_reg)];
        nbr.z_lo   = rd_a[vno_pkg::bank_idx(rx_reg, vno_pkg::dec3(rz_reg))];
        nbr.z_hi   = rd_a[vno_pkg::bank_idx(rx_reg, vno_pkg::inc3(rz_reg))];
    end

endmodule

`default_nettype wire

// ===== sv/voxel_neighbour_occlusion.sv =====
// Top level of the six-neighbour voxel occlusion stencil.
//
// Usage:
//   s_ channel: one density voxel per word, raster order (x fastest, then z,
//   then y) over a volume of dim_x * dim_z * dim_y voxels, margins included.
//   m_ channel: one word for every interior centre voxel (not on any face of
//   the volume); tlast marks the last interior result of each volume.
//   cfg channel: writes dim_x / dim_z / dim_y by index, always ready. A write
//   to one of them restarts the volume at the origin; other indexes are
//   ignored. Write only while the block is idle.
//   Out-of-range dimensions are clamped to 3..32 (x, z) and 3..255 (y).
// Timing:
//   One word accepted per cycle unless m_ stalls. Nine banks by
//   (x mod 3, z mod 3) read the centre and five neighbours in the cycle
//   the voxel above it is accepted; the result then passes stage 1 (store
//   read), then stage 2 (arithmetic), once planes y-1 and y-2 are through.
// Reset / stall:
//   aresetn (sync, low) clears the cursors, both pipeline stages and sets all
//   dimensions to 18; the store is not cleared. While m_tready is low the
//   pending result holds; words that give no result keep flowing, the next
//   one that gives a result waits in the internal stage and s_tready drops.
`default_nettype none

module voxel_neighbour_occlusion (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,     // [7:0] density

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,     // [7:0] occlusion, [12:8] pos_x, [20:13] pos_y,
                                     // [25:21] pos_z, [31:26] zero
    output logic        m_tlast,     // volume_done

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,   // register index
    input  wire  [7:0]  cfg_data
);

    // Configuration, held already clamped
    logic [vno_pkg::DIMXZ_W-1:0] dim_x_reg;
    logic [vno_pkg::DIMXZ_W-1:0] dim_z_reg;
    logic [vno_pkg::DIMY_W-1:0]  dim_y_reg;
    logic                        cfg_wr;
    logic                        cfg_restart;

    // Raster cursors of the next voxel
    logic [vno_pkg::POSXZ_W-1:0] cur_x_reg, cur_x_next;
    logic [vno_pkg::POSXZ_W-1:0] cur_z_reg, cur_z_next;
    logic [vno_pkg::POSY_W-1:0]  cur_y_reg, cur_y_next;

    // Stage 1: accepted voxel, store read in flight
    logic                        st_valid_reg, st_valid_next;
    logic [vno_pkg::DENS_W-1:0]  st_density_reg;
    logic [vno_pkg::POSXZ_W-1:0] st_x_reg;
    logic [vno_pkg::POSXZ_W-1:0] st_z_reg;
    logic [vno_pkg::POSY_W-1:0]  st_y_reg;
    logic                        st_done_reg;

    // Stage 2: result word
    logic                        m_valid_reg, m_valid_next;
    logic [vno_pkg::DENS_W-1:0]  out_occ_reg;
    logic [vno_pkg::POSXZ_W-1:0] out_x_reg;
    logic [vno_pkg::POSXZ_W-1:0] out_z_reg;
    logic [vno_pkg::POSY_W-1:0]  out_y_reg;
    logic                        out_done_reg;

    logic                        out_free;
    logic                        accept;
    logic                        interior;
    logic                        last_centre;
    logic                        x_wrap;
    logic                        z_wrap;
    logic                        y_wrap;
    logic [vno_pkg::DIMXZ_W-1:0] x_ext;
    logic [vno_pkg::DIMXZ_W-1:0] z_ext;
    logic [vno_pkg::DIMY_W:0]    y_ext;

    vno_pkg::nbr_t               nbr;
    logic [vno_pkg::SUM_W-1:0]   nbr_sum;
    logic [vno_pkg::PROD_W-1:0]  nbr_prod;
    logic [vno_pkg::DENS_W-1:0]  nbr_avg;
    logic [vno_pkg::DENS_W-1:0]  occ;

    // ---------------- handshakes ----------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = !st_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;

    // Only a write to a defined register restarts the raster
    assign cfg_restart = cfg_wr && ((cfg_index == vno_pkg::CFG_DIM_X) ||
                                    (cfg_index == vno_pkg::CFG_DIM_Z) ||
                                    (cfg_index == vno_pkg::CFG_DIM_Y));

    // ---------------- position logic ----------------
    assign x_ext = {1'b0, cur_x_reg};
    assign z_ext = {1'b0, cur_z_reg};
    assign y_ext = {1'b0, cur_y_reg};

    // The incoming voxel sits directly above centre (x, y-1, z)
    assign interior = (cur_y_reg >= 8'd2) &&
                      (cur_x_reg != 5'd0) && (x_ext + 6'd2 <= dim_x_reg) &&
                      (cur_z_reg != 5'd0) && (z_ext + 6'd2 <= dim_z_reg);

    assign last_centre = (x_ext + 6'd2 == dim_x_reg) &&
                         (z_ext + 6'd2 == dim_z_reg) &&
                         (y_ext + 9'd1 == {1'b0, dim_y_reg});

    assign x_wrap = (x_ext + 6'd1 >= dim_x_reg);
    assign z_wrap = (z_ext + 6'd1 >= dim_z_reg);
    assign y_wrap = (y_ext + 9'd1 >= {1'b0, dim_y_reg});

    always_comb begin
        cur_x_next = cur_x_reg;
        cur_z_next = cur_z_reg;
        cur_y_next = cur_y_reg;
        if (cfg_restart) begin
            cur_x_next = '0;
            cur_z_next = '0;
            cur_y_next = '0;
        end else if (accept) begin
            cur_x_next = cur_x_reg + 5'd1;
            if (x_wrap) begin
                cur_x_next = '0;
                cur_z_next = cur_z_reg + 5'd1;
                if (z_wrap) begin
                    cur_z_next = '0;
                    cur_y_next = y_wrap ? '0 : cur_y_reg + 8'd1;
                end
            end
        end
    end

    // ---------------- pipeline control ----------------
    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = interior;
        end else if (out_free) begin
            st_valid_next = 1'b0;
        end
        m_valid_next = out_free ? st_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg    <= vno_pkg::DIM_XZ_RESET;
            dim_z_reg    <= vno_pkg::DIM_XZ_RESET;
            dim_y_reg    <= vno_pkg::DIM_Y_RESET;
            cur_x_reg    <= '0;
            cur_z_reg    <= '0;
            cur_y_reg    <= '0;
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    vno_pkg::CFG_DIM_X:
                        dim_x_reg <= vno_pkg::sat_xz(cfg_data[5:0], vno_pkg::DIM_X_MAX);
                    vno_pkg::CFG_DIM_Z:
                        dim_z_reg <= vno_pkg::sat_xz(cfg_data[5:0], vno_pkg::DIM_Z_MAX);
                    vno_pkg::CFG_DIM_Y:
                        dim_y_reg <= vno_pkg::sat_y(cfg_data);
                    default: ;
                endcase
            end
            cur_x_reg    <= cur_x_next;
            cur_z_reg    <= cur_z_next;
            cur_y_reg    <= cur_y_next;
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Stage 1 payload travels alongside the store read
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_density_reg <= s_tdata;
            st_x_reg       <= cur_x_reg;
            st_z_reg       <= cur_z_reg;
            st_y_reg       <= cur_y_reg - 8'd1;
            st_done_reg    <= last_centre;
        end
    end

    // ---------------- plane store ----------------
    vno_plane_store u_store (
        .aclk    (aclk),
        .en      (accept),
        .slot    (cur_y_reg[0]),
        .pos_x   (cur_x_reg),
        .pos_z   (cur_z_reg),
        .wr_data (s_tdata),
        .nbr     (nbr)
    );

    // ---------------- occlusion arithmetic ----------------
    // sum / 6 by reciprocal multiply; exact for sums up to 6 * 255
    always_comb begin
        nbr_sum  = {3'd0, st_density_reg} + {3'd0, nbr.below} +
                   {3'd0, nbr.x_lo} + {3'd0, nbr.x_hi} +
                   {3'd0, nbr.z_lo} + {3'd0, nbr.z_hi};
        nbr_prod = {12'd0, nbr_sum} * vno_pkg::PROD_W'(vno_pkg::RECIP6);
        nbr_avg  = nbr_prod[vno_pkg::RECIP6_SH +: vno_pkg::DENS_W];
        occ      = (nbr_avg > nbr.centre) ? nbr_avg - nbr.centre : '0;
    end

    always_ff @(posedge aclk) begin
        if (out_free && st_valid_reg) begin
            out_occ_reg  <= occ;
            out_x_reg    <= st_x_reg;
            out_y_reg    <= st_y_reg;
            out_z_reg    <= st_z_reg;
            out_done_reg <= st_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_z_reg, out_y_reg, out_x_reg, out_occ_reg};
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire

// ===== sv/vno_checker.sv =====
// Port-level checks for the voxel occlusion stencil, bound to the top level.
`default_nettype none

module vno_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        m_tlast
);

    // Stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Only interior centres are reported: no coordinate on a low face
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:8] != 5'd0) && (m_tdata[20:13] != 8'd0) &&
                     (m_tdata[25:21] != 5'd0) && (m_tdata[31:26] == 6'd0))
        else $error("border centre reported");

    // Input only backs up behind a stalled result
    a_input_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with output free");

endmodule

bind voxel_neighbour_occlusion vno_checker u_vno_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for voxel_neighbour_occlusion: streamed volumes against a stencil predictor.
`default_nettype none

module testbench;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int IDLE_WAIT_MAX = 20_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_VOXELS = 100;
    localparam int DIM_Y_HI      = 255;
    localparam int MAX_REPORTS   = 200;
    localparam int STORE_WORDS   = 2 * vno_pkg::MAX_ROW * vno_pkg::MAX_ROWS;

    // index past the register list, must be ignored by the block
    localparam logic [vno_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [vno_pkg::DENS_W-1:0]  occl;
        logic [vno_pkg::POSXZ_W-1:0] px;
        logic [vno_pkg::POSY_W-1:0]  py;
        logic [vno_pkg::POSXZ_W-1:0] pz;
        logic                        vol_done;
    } occl_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    voxel_neighbour_occlusion u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: register copies, raster cursors and the two-plane store
    logic [vno_pkg::DIMXZ_W-1:0] dim_x_reg = vno_pkg::DIM_XZ_RESET;
    logic [vno_pkg::DIMXZ_W-1:0] dim_z_reg = vno_pkg::DIM_XZ_RESET;
    logic [vno_pkg::DIMY_W-1:0]  dim_y_reg = vno_pkg::DIM_Y_RESET;
    logic [vno_pkg::POSXZ_W-1:0] cur_x = '0;
    logic [vno_pkg::POSXZ_W-1:0] cur_z = '0;
    logic [vno_pkg::POSY_W-1:0]  cur_y = '0;
    logic [vno_pkg::DENS_W-1:0]  plane_mem [0:STORE_WORDS-1];

    occl_result_t expected_occlusions[$];

    int mismatches    = 0;
    int voxels_sent   = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_left     = 0;
    logic hold_trigger = 1'b0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic int eff_dim(input int raw, input int hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic int store_addr(input int slot, input int x, input int z);
        return (slot * vno_pkg::MAX_ROWS + z) * vno_pkg::MAX_ROW + x;
    endfunction

    function automatic int volume_voxels();
        return eff_dim(int'(dim_x_reg), vno_pkg::MAX_ROW) *
               eff_dim(int'(dim_z_reg), vno_pkg::MAX_ROWS) *
               eff_dim(int'(dim_y_reg), DIM_Y_HI);
    endfunction

    // One accepted voxel: queue the occlusion of the center below it, store it, advance
    function automatic void predict_occlusion(input logic [vno_pkg::DENS_W-1:0] dens);
        int dx, dz, dy, x, z, y, slot, prv, sum, val;
        occl_result_t r;
        dx = eff_dim(int'(dim_x_reg), vno_pkg::MAX_ROW);
        dz = eff_dim(int'(dim_z_reg), vno_pkg::MAX_ROWS);
        dy = eff_dim(int'(dim_y_reg), DIM_Y_HI);
        x = int'(cur_x);
        z = int'(cur_z);
        y = int'(cur_y);
        slot = y % 2;
        prv = 1 - slot;
        if (y >= 2 && x >= 1 && x + 2 <= dx && z >= 1 && z + 2 <= dz) begin
            sum = int'(dens) + int'(plane_mem[store_addr(slot, x, z)])
                + int'(plane_mem[store_addr(prv, x - 1, z)])
                + int'(plane_mem[store_addr(prv, x + 1, z)])
                + int'(plane_mem[store_addr(prv, x, z - 1)])
                + int'(plane_mem[store_addr(prv, x, z + 1)]);
            val = sum / 6 - int'(plane_mem[store_addr(prv, x, z)]);
            r.occl     = (val < 0) ? '0 : vno_pkg::DENS_W'(val);
            r.px       = vno_pkg::POSXZ_W'(x);
            r.py       = vno_pkg::POSY_W'(y - 1);
            r.pz       = vno_pkg::POSXZ_W'(z);
            r.vol_done = (x + 2 == dx) && (z + 2 == dz) && (y + 1 == dy);
            expected_occlusions.insert(expected_occlusions.size(), r);
        end
        plane_mem[store_addr(slot, x, z)] = dens;
        x++;
        if (x >= dx) begin
            x = 0;
            z++;
            if (z >= dz) begin
                z = 0;
                y++;
                if (y >= dy) y = 0;
            end
        end
        cur_x = vno_pkg::POSXZ_W'(x);
        cur_z = vno_pkg::POSXZ_W'(z);
        cur_y = vno_pkg::POSY_W'(y);
    endfunction

    function automatic logic [vno_pkg::DENS_W-1:0] next_density();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return vno_pkg::DENS_W'($urandom_range(255));
        endcase
    endfunction

    task automatic set_idle_mode(input idle_mode_t m);
        src_idle_pct = (m == IDLE_SENDER) ? 73 : (m == IDLE_BOTH) ? 27 : 0;
        snk_stall_pct <= (m == IDLE_RECEIVER) ? 73 : (m == IDLE_BOTH) ? 27 : 0;
    endtask

    // Sends one voxel word; leaves s_tvalid high so back-to-back words need no gap
    task automatic send_voxel(input logic [vno_pkg::DENS_W-1:0] dens);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dens;
        do @(posedge aclk); while (!s_tready);
        predict_occlusion(dens);
        voxels_sent++;
    endtask

    task automatic stream_voxels(input int count);
        repeat (count) send_voxel(next_density());
        s_tvalid <= 1'b0;
    endtask

    // Register write; any real index restarts the volume in the predictor too
    task automatic write_reg(input logic [vno_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val,
                             input bit close_cfg);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            vno_pkg::CFG_DIM_X: dim_x_reg = val[vno_pkg::DIMXZ_W-1:0];
            vno_pkg::CFG_DIM_Z: dim_z_reg = val[vno_pkg::DIMXZ_W-1:0];
            vno_pkg::CFG_DIM_Y: dim_y_reg = val;
            default:            ;
        endcase
        if (idx != CFG_UNUSED) begin
            cur_x = '0;
            cur_z = '0;
            cur_y = '0;
        end
        if (close_cfg) cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(input logic [7:0] dx, input logic [7:0] dz, input logic [7:0] dy);
        write_reg(vno_pkg::CFG_DIM_X, dx, 1'b0);
        write_reg(vno_pkg::CFG_DIM_Z, dz, 1'b0);
        write_reg(vno_pkg::CFG_DIM_Y, dy, 1'b1);
    endtask

    // Wait for every queued result, then let the pipeline settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (expected_occlusions.size() != 0 && waited < IDLE_WAIT_MAX) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_occlusions.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_occlusions.size()));
            expected_occlusions.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp, input string at);
        if (got !== exp) report_mismatch($sformatf("%s got %0d want %0d, %s", name, got, exp, at));
    endtask

    // Result side: compare each accepted word in order
    always @(posedge aclk) begin : result_monitor
        occl_result_t want;
        string at;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_occlusions.size() == 0) begin
                report_mismatch($sformatf("unexpected result word 0x%08h", m_tdata));
            end else begin
                want = expected_occlusions.pop_front();
                at = $sformatf("center x%0d y%0d z%0d", want.px, want.py, want.pz);
                check_field("occlusion", 32'(m_tdata[7:0]), 32'(want.occl), at);
                check_field("pos_x", 32'(m_tdata[12:8]), 32'(want.px), at);
                check_field("pos_y", 32'(m_tdata[20:13]), 32'(want.py), at);
                check_field("pos_z", 32'(m_tdata[25:21]), 32'(want.pz), at);
                check_field("pad", 32'(m_tdata[31:26]), 32'd0, at);
                check_field("volume_done", 32'(m_tlast), 32'(want.vol_done), at);
            end
        end
    end

    // Receiver ready: long hold counted down here, random stalls otherwise
    always @(posedge aclk) begin : ready_driver
        if (hold_trigger) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
        if (hold_trigger || hold_left > 1) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Default 18 x 18 x 18 after reset: two planes and the start of the third give
    // the first results; the next write restarts the volume
    task automatic test_reset_dims();
        set_idle_mode(IDLE_NONE);
        stream_voxels(2 * int'(vno_pkg::DIM_XZ_RESET) * int'(vno_pkg::DIM_XZ_RESET) +
                      int'(vno_pkg::DIM_XZ_RESET) + 4);
        wait_idle();
    endtask

    // Smallest volume, twice without a write (wraps): full-scale result, then clamp to zero
    task automatic test_extreme_values();
        set_idle_mode(IDLE_RECEIVER);
        set_dims(8'd3, 8'd3, 8'd3);
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 27; i++) begin
                // voxel 13 is the only interior center of a 3 x 3 x 3 volume
                if ((i == 13) == (v == 0)) send_voxel(8'h00);
                else send_voxel(8'hFF);
            end
        end
        s_tvalid <= 1'b0;
        wait_idle();
    endtask

    // Dimensions outside 3..32 are clamped; upper data bits beyond the field are dropped.
    // Each volume is streamed into its third plane only, far enough to land on the clamp.
    task automatic test_out_of_range();
        set_idle_mode(IDLE_SENDER);
        set_dims(8'hFF, 8'h02, 8'h00);      // 32 x 3 x 3
        stream_voxels(2 * 32 * 3 + 32 + 4);
        wait_idle();
        set_dims(8'h01, 8'hE1, 8'h02);      // 3 x 32 x 3
        stream_voxels(2 * 3 * 32 + 8);
        wait_idle();
    endtask

    // Write to the unused index mid-volume must not restart the raster
    task automatic test_ignored_index();
        set_idle_mode(IDLE_BOTH);
        set_dims(8'd4, 8'd3, 8'd3);
        stream_voxels(15);
        wait_idle();
        write_reg(CFG_UNUSED, 8'($urandom_range(255)), 1'b1);
        stream_voxels(2 * volume_voxels() - 15);
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps offering: block must fill and stall s_tready
    task automatic test_backpressure();
        set_idle_mode(IDLE_NONE);
        set_dims(8'd4, 8'd4, 8'd4);
        hold_trigger <= 1'b1;
        @(posedge aclk);
        hold_trigger <= 1'b0;
        stream_voxels(volume_voxels());
        wait_idle();
    endtask

    // Mostly whole volumes of random size, some cut short and restarted by the next write
    task automatic test_random_volumes();
        int first_count, phase, vol_size;
        logic [vno_pkg::CFG_IDX_W-1:0] idx;
        logic [7:0] raw;
        first_count = voxels_sent;
        phase = 0;
        while (voxels_sent - first_count < RANDOM_VOXELS) begin
            set_idle_mode(idle_mode_t'(phase % 4));
            if ($urandom_range(3) == 0) begin
                idx = vno_pkg::CFG_IDX_W'($urandom_range(2));
                raw = 8'($urandom_range(255)) & ((idx == vno_pkg::CFG_DIM_Y) ? 8'h07 : 8'hC5);
                write_reg(idx, raw, 1'b1);
            end else begin
                set_dims(8'($urandom_range(3, 5)), 8'($urandom_range(3, 4)),
                         8'($urandom_range(3, 4)));
            end
            vol_size = volume_voxels();
            if ($urandom_range(3) == 0) stream_voxels($urandom_range(1, vol_size - 1));
            else stream_voxels(vol_size * $urandom_range(1, 2));
            wait_idle();
            phase++;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_dims();
        test_extreme_values();
        test_out_of_range();
        test_ignored_index();
        test_backpressure();
        test_random_volumes();
        if (mismatches == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/vno_pkg.sv
sv/vno_plane_store.sv
sv/voxel_neighbour_occlusion.sv
sv/vno_checker.sv
test/testbench.sv
